FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared command codes, result event codes and field widths of the
// strict-priority permit queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   // fixed field widths
   localparam int TAG_W    = 16;
   localparam int BUDGET_W = 12;
   localparam int CMD_W    = 2;
   localparam int PRIO_W   = 2;
   localparam int EVENT_W  = 3;
   localparam int WAIT_W   = 6;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [PRIO_W-1:0]   prio_type;
   typedef logic [TAG_W-1:0]    tag_type;
   typedef logic [EVENT_W-1:0]  event_type;
   typedef logic [BUDGET_W-1:0] budget_type;
   typedef logic [WAIT_W-1:0]   wait_type;

   // permit budget after reset
   localparam budget_type BUDGET_RESET = budget_type'(16);

   // commands
   localparam cmd_type CMD_SUBMIT   = 2'd0;
   localparam cmd_type CMD_FINISH   = 2'd1;
   localparam cmd_type CMD_SHUTDOWN = 2'd2;
   localparam cmd_type CMD_UNUSED   = 2'd3;

   // result events
   localparam event_type EV_DISPATCHED    = 3'd0;
   localparam event_type EV_QUEUED        = 3'd1;
   localparam event_type EV_REJ_CLOSED    = 3'd2;
   localparam event_type EV_REJ_FULL      = 3'd3;
   localparam event_type EV_ABORTED       = 3'd4;
   localparam event_type EV_RELEASED      = 3'd5;
   localparam event_type EV_SHUTDOWN_ACK  = 3'd6;
   localparam event_type EV_RELEASE_ERROR = 3'd7;

endpackage

FILE: rtl/core/spq_if.sv
// ----------------------------------------------------------------------------
// spq channel interfaces
// Valid/ready channels for commands into and results out of the queue.
// ----------------------------------------------------------------------------

// command channel
interface spq_req_if;
   logic               valid;
   logic               ready;
   spq_pkg::cmd_type   cmd;
   spq_pkg::prio_type  priority_req;
   spq_pkg::tag_type   task_tag;

   modport source (output valid, output cmd, output priority_req, output task_tag,
                   input ready);
   modport sink   (input valid, input cmd, input priority_req, input task_tag,
                   output ready);
endinterface

// result channel
interface spq_rsp_if;
   logic                 valid;
   logic                 ready;
   spq_pkg::event_type   event_res;
   spq_pkg::tag_type     task_tag_res;
   logic [1:0]           band;
   logic                 last;
   spq_pkg::budget_type  in_flight;
   spq_pkg::wait_type    waiting;

   modport source (output valid, output event_res, output task_tag_res, output band,
                   output last, output in_flight, output waiting, input ready);
   modport sink   (input valid, input event_res, input task_tag_res, input band,
                   input last, input in_flight, input waiting, output ready);
endinterface

FILE: rtl/core/spq_tag_mem.sv
// ----------------------------------------------------------------------------
// spq_tag_mem
// Single write port, single read port tag store with registered read data.
// ----------------------------------------------------------------------------
module spq_tag_mem #(
   parameter  int DEPTH  = 48,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  spq_pkg::tag_type      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output spq_pkg::tag_type      rd_data
);

   spq_pkg::tag_type mem_ff [DEPTH];
   spq_pkg::tag_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/strict_priority_permit_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_permit_queue
// Admission controller with a permit budget and strict-priority FIFO bands.
// ----------------------------------------------------------------------------
// Usage:
//   req carries commands (submit, task finished, shutdown) with a band and a
//   tag; rsp returns result events with the tag, band, last flag, permits in
//   flight and the number of waiting tasks. csr_wr_en/csr_wr_data set the
//   permit budget at any time the block is idle.
// Timing and throughput:
//   submit, release, errors and acks: result registered in the cycle after the
//   transfer, a new command every cycle while results are taken.
//   task finished with tasks waiting: the head tag is read from the
//   synchronous tag memory before the dispatch result is formed.
//   shutdown with waiting tasks: one tag memory read per abort.
// Reset: clears permits, band pointers and counts and the closed flag, and
//   sets the budget to 16. The tag memory is not cleared; an entry is only
//   read after it has been written.
// Stall: the result register holds while rsp.ready is low; no new command
//   is taken and a shutdown drain pauses until the result is taken.
// ----------------------------------------------------------------------------
module strict_priority_permit_queue #(
   parameter int BAND_DEPTH = 16,
   parameter int NUM_BANDS  = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   spq_req_if.sink               req,
   spq_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  spq_pkg::budget_type   csr_wr_data
);

   localparam int PTR_W     = $clog2(BAND_DEPTH);
   localparam int CNT_W     = $clog2(BAND_DEPTH + 1);
   localparam int BAND_W    = $clog2(NUM_BANDS);
   localparam int MEM_DEPTH = NUM_BANDS * BAND_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int TOT_W     = $clog2(MEM_DEPTH + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DATA = 2'd2;

   logic [1:0]             state_ff, state_in;
   spq_pkg::budget_type    budget_ff;
   spq_pkg::budget_type    held_ff, held_in;
   logic                   closed_ff, closed_in;
   logic                   drain_ff, drain_in;
   logic [BAND_W-1:0]      pend_band_ff, pend_band_in;
   logic [PTR_W-1:0]       head_ff [NUM_BANDS];
   logic [PTR_W-1:0]       head_in [NUM_BANDS];
   logic [CNT_W-1:0]       count_ff [NUM_BANDS];
   logic [CNT_W-1:0]       count_in [NUM_BANDS];

   logic                   rsp_valid_ff, rsp_valid_in;
   spq_pkg::event_type     rsp_event_ff, rsp_event_in;
   spq_pkg::tag_type       rsp_tag_ff, rsp_tag_in;
   logic [1:0]             rsp_band_ff, rsp_band_in;
   logic                   rsp_last_ff, rsp_last_in;
   spq_pkg::budget_type    rsp_in_flight_ff;
   spq_pkg::wait_type      rsp_waiting_ff, rsp_waiting_in;
   logic                   load_out;

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   spq_pkg::tag_type       mem_rd_data;

   logic                   out_free;
   logic                   accept;
   logic [BAND_W-1:0]      sub_band;
   logic                   any_wait;
   logic [BAND_W-1:0]      first_band;
   logic [TOT_W-1:0]       total_cur;
   logic [TOT_W-1:0]       total_next;
   logic [PTR_W:0]         tail_sum;
   logic [PTR_W-1:0]       tail_ptr;

   // tag store
   spq_tag_mem #(
      .DEPTH (MEM_DEPTH)
   ) u_tag_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req.task_tag),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   // band of a submit, out-of-range requests go to the lowest band
   always_comb begin
      if ({1'b0, req.priority_req} >= 3'(NUM_BANDS)) begin
         sub_band = BAND_W'(NUM_BANDS - 1);
      end else begin
         sub_band = BAND_W'(req.priority_req);
      end
   end

   // highest non-empty band
   always_comb begin
      any_wait   = 1'b0;
      first_band = '0;
      for (int b = NUM_BANDS - 1; b >= 0; b--) begin
         if (count_ff[b] != '0) begin
            any_wait   = 1'b1;
            first_band = BAND_W'(b);
         end
      end
   end

   // waiting totals before and after this cycle
   always_comb begin
      total_cur  = '0;
      total_next = '0;
      for (int b = 0; b < NUM_BANDS; b++) begin
         total_cur  = total_cur + TOT_W'(count_ff[b]);
         total_next = total_next + TOT_W'(count_in[b]);
      end
   end

   // write slot of the submit band, wraps once at most
   always_comb begin
      tail_sum = {1'b0, head_ff[sub_band]} + (PTR_W+1)'(count_ff[sub_band]);
      if (tail_sum >= (PTR_W+1)'(BAND_DEPTH)) begin
         tail_sum = tail_sum - (PTR_W+1)'(BAND_DEPTH);
      end
      tail_ptr = tail_sum[PTR_W-1:0];
   end

   // sequencer and band bookkeeping
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      closed_in    = closed_ff;
      drain_in     = drain_ff;
      pend_band_in = pend_band_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_event_in = rsp_event_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_band_in  = rsp_band_ff;
      rsp_last_in  = rsp_last_ff;
      load_out     = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ADDR_W'(sub_band) * ADDR_W'(BAND_DEPTH) + ADDR_W'(tail_ptr);
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ADDR_W'(first_band) * ADDR_W'(BAND_DEPTH)
                     + ADDR_W'(head_ff[first_band]);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.cmd)
                  spq_pkg::CMD_SUBMIT: begin
                     load_out    = 1'b1;
                     rsp_tag_in  = req.task_tag;
                     rsp_band_in = 2'(sub_band);
                     rsp_last_in = 1'b1;
                     priority if (closed_ff) begin
                        rsp_event_in = spq_pkg::EV_REJ_CLOSED;
                     end else if (!any_wait && (held_ff < budget_ff)) begin
                        held_in      = held_ff + spq_pkg::budget_type'(1);
                        rsp_event_in = spq_pkg::EV_DISPATCHED;
                     end else if (count_ff[sub_band] == CNT_W'(BAND_DEPTH)) begin
                        rsp_event_in = spq_pkg::EV_REJ_FULL;
                     end else begin
                        mem_wr_en          = 1'b1;
                        count_in[sub_band] = count_ff[sub_band] + CNT_W'(1);
                        rsp_event_in       = spq_pkg::EV_QUEUED;
                     end
                  end
                  spq_pkg::CMD_FINISH: begin
                     priority if (held_ff == '0) begin
                        load_out     = 1'b1;
                        rsp_event_in = spq_pkg::EV_RELEASE_ERROR;
                        rsp_tag_in   = '0;
                        rsp_band_in  = '0;
                        rsp_last_in  = 1'b1;
                     end else if (any_wait) begin
                        // hand the permit to the head of the top band
                        mem_rd_en            = 1'b1;
                        count_in[first_band] = count_ff[first_band] - CNT_W'(1);
                        head_in[first_band]  =
                           (head_ff[first_band] == PTR_W'(BAND_DEPTH - 1)) ?
                           '0 : head_ff[first_band] + PTR_W'(1);
                        pend_band_in         = first_band;
                        drain_in             = 1'b0;
                        state_in             = ST_DATA;
                     end else begin
                        load_out     = 1'b1;
                        held_in      = held_ff - spq_pkg::budget_type'(1);
                        rsp_event_in = spq_pkg::EV_RELEASED;
                        rsp_tag_in   = '0;
                        rsp_band_in  = '0;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  spq_pkg::CMD_SHUTDOWN: begin
                     closed_in = 1'b1;
                     if (closed_ff || !any_wait) begin
                        load_out     = 1'b1;
                        rsp_event_in = spq_pkg::EV_SHUTDOWN_ACK;
                        rsp_tag_in   = '0;
                        rsp_band_in  = '0;
                        rsp_last_in  = 1'b1;
                     end else begin
                        drain_in = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // pop the next task to abort
            mem_rd_en            = 1'b1;
            count_in[first_band] = count_ff[first_band] - CNT_W'(1);
            head_in[first_band]  =
               (head_ff[first_band] == PTR_W'(BAND_DEPTH - 1)) ?
               '0 : head_ff[first_band] + PTR_W'(1);
            pend_band_in         = first_band;
            state_in             = ST_DATA;
         end
         ST_DATA: begin
            if (out_free) begin
               load_out     = 1'b1;
               rsp_tag_in   = mem_rd_data;
               rsp_band_in  = 2'(pend_band_ff);
               rsp_event_in = drain_ff ? spq_pkg::EV_ABORTED : spq_pkg::EV_DISPATCHED;
               rsp_last_in  = drain_ff ? (total_cur == '0) : 1'b1;
               state_in     = (drain_ff && (total_cur != '0)) ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_waiting_in = spq_pkg::wait_type'(8'(total_next));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         closed_ff    <= 1'b0;
         drain_ff     <= 1'b0;
         pend_band_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BANDS; b++) begin
            head_ff[b]  <= '0;
            count_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         closed_ff    <= closed_in;
         drain_ff     <= drain_in;
         pend_band_ff <= pend_band_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
   end

   // permit budget register
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= spq_pkg::BUDGET_RESET;
      end else if (csr_wr_en) begin
         budget_ff <= csr_wr_data;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_event_ff     <= rsp_event_in;
         rsp_tag_ff       <= rsp_tag_in;
         rsp_band_ff      <= rsp_band_in;
         rsp_last_ff      <= rsp_last_in;
         rsp_in_flight_ff <= held_in;
         rsp_waiting_ff   <= rsp_waiting_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.event_res    = rsp_event_ff;
   assign rsp.task_tag_res = rsp_tag_ff;
   assign rsp.band         = rsp_band_ff;
   assign rsp.last         = rsp_last_ff;
   assign rsp.in_flight    = rsp_in_flight_ff;
   assign rsp.waiting      = rsp_waiting_ff;

   // waiting tasks never exceed the store
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_cur <= TOT_W'(MEM_DEPTH))
      else $error("waiting count beyond store size");

   // a drain read only starts with a task left to pop
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> any_wait)
      else $error("drain read with all bands empty");

   // a finish with waiting tasks keeps the permit count
   a_handoff_permits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA && !drain_ff) |-> $stable(held_ff))
      else $error("permit count moved during hand-off");

endmodule

FILE: dv/strict_priority_permit_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_permit_queue_tb
// Self-checking bench for the permit queue. Commands go in through a driver
// fed from a backlog; a shadow of the bands, permits and closed flag predicts
// every result, and a monitor checks each result transfer in order. Phases
// move the permit budget through its extremes and vary sender idling and
// receiver stalls; the run ends with bands filled under a zero budget and a
// shutdown that aborts the lot.
// ----------------------------------------------------------------------------
module strict_priority_permit_queue_tb;

   localparam int BAND_DEPTH    = 16;
   localparam int NUM_BANDS     = 3;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      spq_pkg::cmd_type  cmd;
      spq_pkg::prio_type prio;
      spq_pkg::tag_type  tag;
   } command_type;

   typedef struct {
      spq_pkg::event_type  ev;
      spq_pkg::tag_type    tag;
      logic [1:0]          band;
      logic                last;
      spq_pkg::budget_type in_flight;
      spq_pkg::wait_type   waiting;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   spq_pkg::budget_type csr_wr_data;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   strict_priority_permit_queue #(
      .BAND_DEPTH (BAND_DEPTH),
      .NUM_BANDS  (NUM_BANDS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the block state
   spq_pkg::tag_type    band_tags [NUM_BANDS][BAND_DEPTH];
   int unsigned         band_head [NUM_BANDS];
   int unsigned         band_fill [NUM_BANDS];
   int unsigned         permits_held;
   bit                  is_closed;
   spq_pkg::budget_type budget_now;

   command_type command_backlog [$];
   outcome_type outcome_q [$];
   int          send_idle_pct;
   int          rsp_stall_pct;
   int          fault_count;
   int          cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned waiting_total();
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < NUM_BANDS; i++) sum += band_fill[i];
      return sum;
   endfunction

   function automatic spq_pkg::tag_type pop_waiting(int unsigned b);
      spq_pkg::tag_type t;
      t = band_tags[b][band_head[b]];
      band_head[b] = (band_head[b] + 1) % BAND_DEPTH;
      band_fill[b]--;
      return t;
   endfunction

   function automatic void note_outcome(spq_pkg::event_type ev, spq_pkg::tag_type tag,
                                        int unsigned bnd, bit last);
      outcome_type o;
      o.ev        = ev;
      o.tag       = tag;
      o.band      = bnd[1:0];
      o.last      = last;
      o.in_flight = spq_pkg::budget_type'(permits_held);
      o.waiting   = spq_pkg::wait_type'(waiting_total());
      outcome_q.insert(outcome_q.size(), o);
   endfunction

   // expected results of one accepted command
   function automatic void admission_outcome(spq_pkg::cmd_type c, spq_pkg::prio_type p,
                                             spq_pkg::tag_type t);
      int unsigned      b;
      bit               handed;
      bit               was_closed;
      spq_pkg::tag_type head_tag;
      b = (p >= NUM_BANDS) ? NUM_BANDS - 1 : p;
      case (c)
         spq_pkg::CMD_SUBMIT: begin
            if (is_closed) begin
               note_outcome(spq_pkg::EV_REJ_CLOSED, t, b, 1'b1);
            end else if (waiting_total() == 0 && permits_held < budget_now) begin
               permits_held++;
               note_outcome(spq_pkg::EV_DISPATCHED, t, b, 1'b1);
            end else if (band_fill[b] >= BAND_DEPTH) begin
               note_outcome(spq_pkg::EV_REJ_FULL, t, b, 1'b1);
            end else begin
               band_tags[b][(band_head[b] + band_fill[b]) % BAND_DEPTH] = t;
               band_fill[b]++;
               note_outcome(spq_pkg::EV_QUEUED, t, b, 1'b1);
            end
         end
         spq_pkg::CMD_FINISH: begin
            if (permits_held == 0) begin
               note_outcome(spq_pkg::EV_RELEASE_ERROR, '0, 0, 1'b1);
            end else begin
               // permit passes to the head of the highest non-empty band
               handed = 1'b0;
               for (int i = 0; i < NUM_BANDS; i++) begin
                  if (!handed && band_fill[i] != 0) begin
                     handed   = 1'b1;
                     head_tag = pop_waiting(i);
                     note_outcome(spq_pkg::EV_DISPATCHED, head_tag, i, 1'b1);
                  end
               end
               if (!handed) begin
                  permits_held--;
                  note_outcome(spq_pkg::EV_RELEASED, '0, 0, 1'b1);
               end
            end
         end
         spq_pkg::CMD_SHUTDOWN: begin
            was_closed = is_closed;
            is_closed  = 1'b1;
            if (was_closed || waiting_total() == 0) begin
               note_outcome(spq_pkg::EV_SHUTDOWN_ACK, '0, 0, 1'b1);
            end else begin
               // abort everything waiting, high band first
               for (int i = 0; i < NUM_BANDS; i++) begin
                  while (band_fill[i] != 0) begin
                     head_tag = pop_waiting(i);
                     note_outcome(spq_pkg::EV_ABORTED, head_tag, i, waiting_total() == 0);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      if (fault_count < 64) $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fault_count++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // command driver
   always @(posedge clock) begin : drive_commands
      command_type pick;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            admission_outcome(req_bus.cmd, req_bus.priority_req, req_bus.task_tag);
         if (!req_bus.valid || req_bus.ready) begin
            if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               pick = command_backlog[0];
               command_backlog.delete(0);
               req_bus.valid        <= 1'b1;
               req_bus.cmd          <= pick.cmd;
               req_bus.priority_req <= pick.prio;
               req_bus.task_tag     <= pick.tag;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin : watch_results
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (outcome_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result event %0d tag %h",
                                      rsp_bus.event_res, rsp_bus.task_tag_res));
         end else begin
            want = outcome_q[0];
            outcome_q.delete(0);
            check_field("event", rsp_bus.event_res, want.ev);
            check_field("tag", rsp_bus.task_tag_res, want.tag);
            check_field("band", rsp_bus.band, want.band);
            check_field("last", rsp_bus.last, want.last);
            check_field("in_flight", rsp_bus.in_flight, want.in_flight);
            check_field("waiting", rsp_bus.waiting, want.waiting);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[strict_priority_permit_queue] ERROR");
         $finish;
      end
   end

   task automatic queue_command(spq_pkg::cmd_type c, spq_pkg::prio_type p,
                                spq_pkg::tag_type t);
      command_type item;
      item.cmd  = c;
      item.prio = p;
      item.tag  = t;
      command_backlog.insert(command_backlog.size(), item);
   endtask

   task automatic queue_random(int count, int submit_pct);
      int r;
      spq_pkg::cmd_type c;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < submit_pct) c = spq_pkg::CMD_SUBMIT;
         else if (r < 97)    c = spq_pkg::CMD_FINISH;
         else                c = spq_pkg::CMD_UNUSED;
         queue_command(c, spq_pkg::prio_type'($urandom_range(3)),
                       spq_pkg::tag_type'($urandom));
      end
   endtask

   // submits spread evenly over the bands, the low band by either code
   task automatic queue_band_fill(int count);
      int unsigned b;
      for (int i = 0; i < count; i++) begin
         b = $urandom_range(NUM_BANDS - 1);
         if (b == NUM_BANDS - 1 && $urandom_range(1) == 1) b = 3;
         queue_command(spq_pkg::CMD_SUBMIT, spq_pkg::prio_type'(b),
                       spq_pkg::tag_type'($urandom));
      end
   endtask

   // wait until every command is taken and every result has come
   task automatic await_quiet();
      int guard;
      guard = 0;
      while ((command_backlog.size() != 0 || req_bus.valid === 1'b1 ||
              outcome_q.size() != 0) && guard < QUIET_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_budget(spq_pkg::budget_type v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      budget_now = v;
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   initial begin
      int unsigned spare;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      for (int i = 0; i < NUM_BANDS; i++) begin
         band_head[i] = 0;
         band_fill[i] = 0;
      end
      permits_held  = 0;
      is_closed     = 1'b0;
      budget_now    = spq_pkg::BUDGET_RESET;
      set_idling(0, 0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset budget: completion with nothing held, unused command, submits that dispatch
      queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_UNUSED, 2'd3, 16'hFFFF);
      queue_command(spq_pkg::CMD_SUBMIT, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_SUBMIT, 2'd3, 16'hFFFF);
      queue_command(spq_pkg::CMD_SUBMIT, 2'd1, 16'h1234);
      await_quiet();

      // zero budget, well below the permits held: submits queue, completions hand off
      program_budget('0);
      queue_command(spq_pkg::CMD_SUBMIT, 2'd2, 16'hA5A5);
      queue_command(spq_pkg::CMD_SUBMIT, 2'd0, 16'h5A5A);
      queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_SUBMIT, 2'd1, 16'h8001);
      queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      await_quiet();

      // balanced traffic, no idling
      program_budget(spq_pkg::budget_type'(16));
      queue_random(40, 50);
      await_quiet();

      // full budget, sender idling
      program_budget('1);
      set_idling(49, 0);
      queue_random(35, 55);
      await_quiet();

      // single permit under a flood of submits, receiver stalling
      program_budget(spq_pkg::budget_type'(1));
      set_idling(0, 49);
      queue_random(45, 85);
      await_quiet();

      // both sides idling
      program_budget(spq_pkg::budget_type'(2));
      set_idling(17, 17);
      queue_random(30, 45);
      await_quiet();

      // hand off and release everything so that nothing waits or is held
      spare = waiting_total() + permits_held;
      for (int i = 0; i < spare; i++) queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      await_quiet();

      // fill the bands under a zero budget, completion with tasks waiting but
      // no permit held, then shutdown, repeated shutdown and traffic once closed
      program_budget('0);
      queue_band_fill(30);
      queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      queue_band_fill(32);
      queue_command(spq_pkg::CMD_SHUTDOWN, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_SHUTDOWN, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_SUBMIT, 2'd3, spq_pkg::tag_type'($urandom));
      queue_command(spq_pkg::CMD_FINISH, 2'd0, 16'h0000);
      queue_command(spq_pkg::CMD_UNUSED, 2'd0, 16'h0000);
      await_quiet();

      if (command_backlog.size() != 0 || req_bus.valid === 1'b1)
         report_mismatch($sformatf("%0d commands never taken", command_backlog.size()));
      if (outcome_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", outcome_q.size()));
      if (fault_count == 0) $display("[strict_priority_permit_queue] OK");
      else                  $display("[strict_priority_permit_queue] ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_tag_mem.sv
rtl/core/strict_priority_permit_queue.sv
dv/strict_priority_permit_queue_tb.sv
